FILE: rtl/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg
// Shared types, codes and sizes of the first-match packet filter.
// ----------------------------------------------------------------------------
package fmpf_pkg;

   localparam int RULES_PER_DIRECTION = 32;
   localparam int DEPTH               = 2 * RULES_PER_DIRECTION;
   localparam int LEN_W               = $clog2(RULES_PER_DIRECTION + 1);

   // commands
   localparam logic [2:0] CMD_CHECK     = 3'd0;
   localparam logic [2:0] CMD_ADD       = 3'd1;
   localparam logic [2:0] CMD_REM_ID    = 3'd2;
   localparam logic [2:0] CMD_REM_OWNER = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // protocol and version codes
   localparam logic [1:0] PROTO_ANY   = 2'd0;
   localparam logic [1:0] L4_TCP      = 2'd1;
   localparam logic [1:0] L4_UDP      = 2'd2;
   localparam logic [1:0] PROTO_OTHER = 2'd3;
   localparam logic [1:0] VER_NONE    = 2'd0;
   localparam logic [1:0] VER_V4      = 2'd1;
   localparam logic [1:0] VER_V6      = 2'd2;
   localparam logic [1:0] VER_UNKNOWN = 2'd3;

   // rule actions
   localparam logic [1:0] ACT_ALLOW = 2'd1;
   localparam logic [1:0] ACT_DENY  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FILTER_EN  = 2'd0;
   localparam logic [1:0] CSR_IN_DEFAULT = 2'd1;
   localparam logic [1:0] CSR_OUT_DEFAULT = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        direction;
      logic [1:0]  protocol;
      logic [1:0]  ip_ver;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [7:0]  prefix_length;
      logic [1:0]  rule_action;
      logic        related_flag;
      logic [31:0] tag;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic [1:0]  status;
      logic [31:0] assigned_id;
      logic [6:0]  rule_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] pfrom;
      logic [15:0] pto;
      logic [7:0]  prefix;
      logic [1:0]  ver;
      logic [1:0]  proto;
      logic        allow;
      logic [31:0] id;
      logic [15:0] owner;
   } rule_type;

   // what every cell compares against
   typedef struct packed {
      logic [1:0]  proto;
      logic [1:0]  ver;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [15:0] port;
      logic [31:0] id;
      logic [15:0] owner;
   } key_type;

   typedef struct packed {
      logic pkt;
      logic id;
      logic own;
   } hit_type;

   // cell control
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

FILE: rtl/fmpf_cell.sv
// ----------------------------------------------------------------------------
// fmpf_cell
// One rule slot: holds a rule, loads a new one on an add, compares it with
// the current key, and takes its upper neighbor's rule when the list closes a gap.
// ----------------------------------------------------------------------------
module fmpf_cell (
   input  logic                   clock,
   input  fmpf_pkg::cell_ctl_type ctl,
   input  fmpf_pkg::rule_type     nb_rule,
   input  fmpf_pkg::rule_type     new_rule,
   input  fmpf_pkg::key_type      key,
   output fmpf_pkg::rule_type     rule,
   output fmpf_pkg::hit_type      hit
);

   fmpf_pkg::rule_type rule_ff, rule_in;

   logic [127:0] m128;
   logic [31:0]  m32;
   logic         addr_ok, proto_ok, ver_ok, port_ok;

   always_comb begin
      rule_in = rule_ff;
      if (ctl.load) begin
         rule_in = new_rule;
      end else if (ctl.shift) begin
         rule_in = nb_rule;
      end
   end

   always_ff @(posedge clock) begin
      rule_ff <= rule_in;
   end

   // prefix masks, counted from the top bit
   always_comb begin
      for (int j = 0; j < 128; j++) begin
         m128[j] = (9'(j) + {1'b0, rule_ff.prefix}) >= 9'd128;
      end
      for (int j = 0; j < 32; j++) begin
         m32[j] = (9'(j) + {1'b0, rule_ff.prefix}) >= 9'd32;
      end
   end

   always_comb begin
      if (rule_ff.prefix == 8'd0) begin
         addr_ok = 1'b1;
      end else if (rule_ff.ver == fmpf_pkg::VER_V4) begin
         addr_ok = ((rule_ff.addr_lo[31:0] ^ key.addr_lo[31:0]) & m32) == 32'd0;
      end else begin
         addr_ok = (({rule_ff.addr_hi, rule_ff.addr_lo} ^ {key.addr_hi, key.addr_lo})
                    & m128) == 128'd0;
      end
      proto_ok = (rule_ff.proto == fmpf_pkg::PROTO_ANY) || (rule_ff.proto == key.proto);
      ver_ok   = (rule_ff.ver == fmpf_pkg::VER_NONE) ||
                 ((rule_ff.ver == key.ver) && addr_ok);
      port_ok  = (rule_ff.pfrom == 16'd0) ||
                 ((key.port >= rule_ff.pfrom) && (key.port <= rule_ff.pto));
      hit.pkt  = proto_ok && ver_ok && port_ok;
      hit.id   = rule_ff.id == key.id;
      hit.own  = rule_ff.owner == key.owner;
   end

   assign rule = rule_ff;

endmodule

FILE: rtl/first_match_packet_filter_core.sv
// ----------------------------------------------------------------------------
// first_match_packet_filter_core
// Two ordered rule lists (inbound, outbound) held in a chain of rule cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on rsp_data for exactly one cycle with rsp_valid high, and must be
// captured then. Check, add, remove by id, clear and unknown commands keep
// busy high through S_SCAN, where every cell compares against the item, and
// S_PICK, which picks the first hit of the list and updates it. The result
// shows in the cycle after S_PICK, when busy is already low, so the next item
// can be taken in that same cycle. Remove by owner passes through S_SCAN and
// S_PICK once more for every rule it deletes, since a deletion closes the gap
// by shifting each cell above it down one place and the list is compared
// again. The configuration port never stalls (csr_ready is always high).
// ----------------------------------------------------------------------------
module first_match_packet_filter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fmpf_pkg::req_type req_data,
   output logic              rsp_valid,
   output fmpf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic              csr_data
);

   localparam int RPD = fmpf_pkg::RULES_PER_DIRECTION;
   localparam int LW  = fmpf_pkg::LEN_W;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK} state_type;

   state_type            state_ff;
   fmpf_pkg::req_type    req_ff;
   logic [1:0][LW-1:0]   len_ff;
   logic [31:0]          nid_ff;
   logic                 en_ff, in_def_ff, out_def_ff;
   fmpf_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;
   logic [1:0][RPD-1:0]  pkt_ff, id_ff, own_ff;

   // cell chain
   fmpf_pkg::key_type                  key;
   fmpf_pkg::rule_type [1:0][RPD-1:0]  rules;
   fmpf_pkg::hit_type  [1:0][RPD-1:0]  hits;
   fmpf_pkg::cell_ctl_type [1:0][RPD-1:0] ctl;
   fmpf_pkg::rule_type                 new_rule;

   // pick decisions
   logic [1:0][RPD-1:0]  valid, vp, tgt, allow_vec;
   logic [RPD-1:0]       first_pkt, first_tgt, region;
   logic                 dsel, del, verdict, add_ok, add_room;
   logic [1:0][LW-1:0]   len_in;
   logic [31:0]          id_take, nid_in;
   logic [LW:0]          total;
   fmpf_pkg::rsp_type    rsp_in;
   logic                 again;

   assign key.proto   = req_ff.protocol;
   assign key.ver     = req_ff.ip_ver;
   assign key.addr_hi = req_ff.addr_high;
   assign key.addr_lo = req_ff.addr_low;
   // inbound checks the local port, outbound the remote one
   assign key.port    = req_ff.direction ? req_ff.port_low : req_ff.port_high;
   assign key.id      = req_ff.tag;
   assign key.owner   = req_ff.tag[15:0];

   assign new_rule.addr_hi = req_ff.addr_high;
   assign new_rule.addr_lo = req_ff.addr_low;
   assign new_rule.pfrom   = req_ff.port_low;
   assign new_rule.pto     = req_ff.port_high;
   assign new_rule.prefix  = req_ff.prefix_length;
   assign new_rule.ver     = req_ff.ip_ver;
   assign new_rule.proto   = req_ff.protocol;
   assign new_rule.allow   = req_ff.rule_action == fmpf_pkg::ACT_ALLOW;
   assign new_rule.id      = id_take;
   assign new_rule.owner   = req_ff.tag[15:0];

   for (genvar d = 0; d < 2; d++) begin : g_list
      for (genvar k = 0; k < RPD; k++) begin : g_cell
         fmpf_pkg::rule_type nb;
         if (k == RPD - 1) begin : g_top
            assign nb = rules[d][k];
         end else begin : g_mid
            assign nb = rules[d][k+1];
         end
         fmpf_cell u_cell (
            .clock    (clock),
            .ctl      (ctl[d][k]),
            .nb_rule  (nb),
            .new_rule (new_rule),
            .key      (key),
            .rule     (rules[d][k]),
            .hit      (hits[d][k])
         );
      end
   end

   // ---- decision logic for the pick cycle ----
   always_comb begin
      for (int d = 0; d < 2; d++) begin
         for (int k = 0; k < RPD; k++) begin
            valid[d][k]     = LW'(k) < len_ff[d];
            allow_vec[d][k] = rules[d][k].allow;
         end
         vp[d] = pkt_ff[d] & valid[d];
         if (req_ff.cmd == fmpf_pkg::CMD_REM_ID) begin
            tgt[d] = (req_ff.tag != 32'd0) ? (id_ff[d] & valid[d]) : '0;
         end else if (req_ff.cmd == fmpf_pkg::CMD_REM_OWNER) begin
            tgt[d] = (req_ff.tag[15:0] != 16'd0) ? (own_ff[d] & valid[d]) : '0;
         end else begin
            tgt[d] = '0;
         end
      end

      // first hit as a one-hot word
      first_pkt = vp[req_ff.direction] & (~vp[req_ff.direction] + 1'b1);
      dsel      = ~(|tgt[0]);
      first_tgt = tgt[dsel] & (~tgt[dsel] + 1'b1);
      region    = ~(first_tgt - 1'b1);
      del       = (|tgt[0]) || (|tgt[1]);

      // check verdict
      if ((req_ff.protocol != fmpf_pkg::L4_TCP) &&
          (req_ff.protocol != fmpf_pkg::L4_UDP)) begin
         verdict = 1'b1;
      end else if (req_ff.ip_ver == fmpf_pkg::VER_V4 &&
                   req_ff.addr_low[31:24] == 8'd127) begin
         verdict = 1'b1;
      end else if (req_ff.ip_ver == fmpf_pkg::VER_V6 &&
                   req_ff.addr_high == 64'd0 && req_ff.addr_low == 64'd1) begin
         verdict = 1'b1;
      end else if (req_ff.ip_ver != fmpf_pkg::VER_V4 &&
                   req_ff.ip_ver != fmpf_pkg::VER_V6) begin
         verdict = 1'b0;
      end else if (req_ff.related_flag || !en_ff) begin
         verdict = 1'b1;
      end else if (|vp[req_ff.direction]) begin
         verdict = |(first_pkt & allow_vec[req_ff.direction]);
      end else begin
         verdict = req_ff.direction ? out_def_ff : in_def_ff;
      end

      // add validation
      add_ok = !((req_ff.rule_action != fmpf_pkg::ACT_ALLOW &&
                  req_ff.rule_action != fmpf_pkg::ACT_DENY) ||
                 req_ff.protocol == fmpf_pkg::PROTO_OTHER ||
                 req_ff.ip_ver == fmpf_pkg::VER_UNKNOWN ||
                 (req_ff.ip_ver == fmpf_pkg::VER_V4 && req_ff.prefix_length > 8'd32) ||
                 (req_ff.ip_ver == fmpf_pkg::VER_V6 && req_ff.prefix_length > 8'd128) ||
                 (req_ff.ip_ver == fmpf_pkg::VER_NONE && req_ff.prefix_length != 8'd0) ||
                 ((req_ff.port_low == 16'd0) != (req_ff.port_high == 16'd0)) ||
                 (req_ff.port_low != 16'd0 && req_ff.port_low > req_ff.port_high));
      add_room = len_ff[req_ff.direction] < LW'(RPD);
      // id zero is skipped
      id_take  = (nid_ff == 32'd0) ? 32'd1 : nid_ff;
      nid_in   = nid_ff;

      ctl    = '0;
      len_in = len_ff;
      again  = 1'b0;
      rsp_in = '0;
      rsp_in.status = fmpf_pkg::ST_OK;

      case (req_ff.cmd)
         fmpf_pkg::CMD_CHECK: begin
            rsp_in.allowed = verdict;
         end
         fmpf_pkg::CMD_ADD: begin
            if (!add_ok) begin
               rsp_in.status = fmpf_pkg::ST_INVALID;
            end else begin
               nid_in = id_take + 32'd1;
               if (!add_room) begin
                  rsp_in.status = fmpf_pkg::ST_FULL;
               end else begin
                  for (int k = 0; k < RPD; k++) begin
                     ctl[req_ff.direction][k].load = len_ff[req_ff.direction] == LW'(k);
                  end
                  len_in[req_ff.direction] = len_ff[req_ff.direction] + 1'b1;
                  rsp_in.assigned_id = id_take;
               end
            end
         end
         fmpf_pkg::CMD_REM_ID, fmpf_pkg::CMD_REM_OWNER: begin
            if (del) begin
               for (int k = 0; k < RPD; k++) begin
                  ctl[dsel][k].shift = region[k];
               end
               len_in[dsel] = len_ff[dsel] - 1'b1;
            end
            if (req_ff.cmd == fmpf_pkg::CMD_REM_ID) begin
               if (req_ff.tag == 32'd0) begin
                  rsp_in.status = fmpf_pkg::ST_INVALID;
               end else if (!del) begin
                  rsp_in.status = fmpf_pkg::ST_NOT_FOUND;
               end
            end else begin
               // owner removal repeats until no rule of the owner is left
               again = del;
            end
         end
         fmpf_pkg::CMD_CLEAR: begin
            len_in = '0;
         end
         default: begin
            rsp_in.status = fmpf_pkg::ST_INVALID;
         end
      endcase

      if (state_ff != S_PICK) begin
         ctl    = '0;
         len_in = len_ff;
         nid_in = nid_ff;
      end

      total = {1'b0, len_in[0]} + {1'b0, len_in[1]};
      rsp_in.rule_total = 7'(total);
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         nid_ff       <= 32'd1;
         en_ff        <= 1'b1;
         in_def_ff    <= 1'b0;
         out_def_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         len_ff       <= len_in;
         nid_ff       <= nid_in;
         if (csr_valid) begin
            case (csr_index)
               fmpf_pkg::CSR_FILTER_EN:   en_ff      <= csr_data;
               fmpf_pkg::CSR_IN_DEFAULT:  in_def_ff  <= csr_data;
               fmpf_pkg::CSR_OUT_DEFAULT: out_def_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               state_ff <= S_PICK;
            end
            S_PICK: begin
               if (again) begin
                  state_ff <= S_SCAN;
               end else begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
      end
      if (state_ff == S_SCAN) begin
         for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < RPD; k++) begin
               pkt_ff[d][k] <= hits[d][k].pkt;
               id_ff[d][k]  <= hits[d][k].id;
               own_ff[d][k] <= hits[d][k].own;
            end
         end
      end
      if (state_ff == S_PICK) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: rtl/fmpf_checker.sv
// ----------------------------------------------------------------------------
// fmpf_checker
// Port-level checks of the packet filter, bound to the top level.
// ----------------------------------------------------------------------------
module fmpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fmpf_pkg::req_type req_data,
   input logic              rsp_valid,
   input fmpf_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_index,
   input logic              csr_data
);

   a_taken_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item taken but block not busy");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_id_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.assigned_id != 32'd0 |-> rsp_data.status == fmpf_pkg::ST_OK)
      else $error("id given with error status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy) else $error("activity after reset");

endmodule

bind first_match_packet_filter_core fmpf_checker u_fmpf_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-match packet filter. A behavioral model of
// both rule lists predicts each result; directed tests cover validation, ids,
// removal, loopback and prefix edges, then random rule sets drive checks.
// ----------------------------------------------------------------------------
module tb;

   // command and action codes the block treats as invalid
   localparam logic [2:0] CMD_RSVD_LO = 3'd5;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_RSVD    = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   fmpf_pkg::req_type req_data = '0;
   logic    rsp_valid;
   fmpf_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0] csr_index = '0;
   logic    csr_data = 1'b0;

   first_match_packet_filter_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // model state: one rule list per direction
   fmpf_pkg::rule_type rule_list [2][$];
   logic [31:0] next_id;
   logic       filt_en, in_dflt, out_dflt;
   fmpf_pkg::rsp_type pending_rsp [$];
   int         mismatch_count = 0;
   bit         idle_enable = 1'b1;

   function automatic logic prefix_hit(fmpf_pkg::rule_type r, fmpf_pkg::req_type p);
      logic [127:0] mask, ra, pa;
      if (r.prefix == 8'd0) return 1'b1;
      if (r.ver == fmpf_pkg::VER_V4) begin
         mask = {96'd0, ~(32'hFFFF_FFFF >> r.prefix)};
         ra = {96'd0, r.addr_lo[31:0]};
         pa = {96'd0, p.addr_low[31:0]};
      end else begin
         mask = ~({128{1'b1}} >> r.prefix);
         ra = {r.addr_hi, r.addr_lo};
         pa = {p.addr_high, p.addr_low};
      end
      return ((ra ^ pa) & mask) == 128'd0;
   endfunction

   function automatic logic packet_verdict(fmpf_pkg::req_type p);
      logic [15:0]        port;
      fmpf_pkg::rule_type r;
      port = p.direction ? p.port_low : p.port_high;
      if (p.protocol != fmpf_pkg::L4_TCP && p.protocol != fmpf_pkg::L4_UDP) return 1'b1;
      if (p.ip_ver == fmpf_pkg::VER_V4) begin
         if (p.addr_low[31:24] == 8'd127) return 1'b1;
      end else if (p.ip_ver == fmpf_pkg::VER_V6) begin
         if (p.addr_high == 64'd0 && p.addr_low == 64'd1) return 1'b1;
      end else begin
         return 1'b0;
      end
      if (p.related_flag || !filt_en) return 1'b1;
      for (int i = 0; i < rule_list[p.direction].size(); i++) begin
         r = rule_list[p.direction][i];
         if (r.proto != fmpf_pkg::PROTO_ANY && r.proto != p.protocol) continue;
         if (r.ver != fmpf_pkg::VER_NONE) begin
            if (r.ver != p.ip_ver) continue;
            if (!prefix_hit(r, p)) continue;
         end
         if (r.pfrom != 16'd0 && (port < r.pfrom || port > r.pto)) continue;
         return r.allow;
      end
      return p.direction ? out_dflt : in_dflt;
   endfunction

   function automatic fmpf_pkg::rsp_type filter_outcome(fmpf_pkg::req_type q);
      fmpf_pkg::rsp_type  o;
      fmpf_pkg::rule_type r;
      logic               bad, found;
      o = '0;
      case (q.cmd)
         fmpf_pkg::CMD_CHECK: o.allowed = packet_verdict(q);
         fmpf_pkg::CMD_ADD: begin
            bad = (q.rule_action != fmpf_pkg::ACT_ALLOW &&
                   q.rule_action != fmpf_pkg::ACT_DENY) ||
                  q.protocol == fmpf_pkg::PROTO_OTHER || q.ip_ver == fmpf_pkg::VER_UNKNOWN ||
                  (q.ip_ver == fmpf_pkg::VER_V4 && q.prefix_length > 8'd32) ||
                  (q.ip_ver == fmpf_pkg::VER_V6 && q.prefix_length > 8'd128) ||
                  (q.ip_ver == fmpf_pkg::VER_NONE && q.prefix_length != 8'd0) ||
                  ((q.port_low == 16'd0) != (q.port_high == 16'd0)) ||
                  (q.port_low != 16'd0 && q.port_low > q.port_high);
            if (bad) o.status = fmpf_pkg::ST_INVALID;
            else begin
               r.id = next_id++;
               if (r.id == 32'd0) r.id = next_id++;
               if (rule_list[q.direction].size() >= fmpf_pkg::RULES_PER_DIRECTION)
                  o.status = fmpf_pkg::ST_FULL;
               else begin
                  r.addr_hi = q.addr_high;
                  r.addr_lo = q.addr_low;
                  r.pfrom   = q.port_low;
                  r.pto     = q.port_high;
                  r.prefix  = q.prefix_length;
                  r.ver     = q.ip_ver;
                  r.proto   = q.protocol;
                  r.allow   = (q.rule_action == fmpf_pkg::ACT_ALLOW);
                  r.owner   = q.tag[15:0];
                  rule_list[q.direction].push_back(r);
                  o.assigned_id = r.id;
               end
            end
         end
         fmpf_pkg::CMD_REM_ID: begin
            found = 1'b0;
            if (q.tag == 32'd0) o.status = fmpf_pkg::ST_INVALID;
            else begin
               for (int d = 0; d < 2 && !found; d++)
                  for (int i = 0; i < rule_list[d].size() && !found; i++)
                     if (rule_list[d][i].id == q.tag) begin
                        rule_list[d].delete(i);
                        found = 1'b1;
                     end
               if (!found) o.status = fmpf_pkg::ST_NOT_FOUND;
            end
         end
         fmpf_pkg::CMD_REM_OWNER: begin
            if (q.tag[15:0] != 16'd0)
               for (int d = 0; d < 2; d++)
                  for (int i = rule_list[d].size() - 1; i >= 0; i--)
                     if (rule_list[d][i].owner == q.tag[15:0]) rule_list[d].delete(i);
         end
         fmpf_pkg::CMD_CLEAR: begin
            rule_list[0].delete();
            rule_list[1].delete();
         end
         default: o.status = fmpf_pkg::ST_INVALID;
      endcase
      o.rule_total = 7'(rule_list[0].size() + rule_list[1].size());
      return o;
   endfunction

   // check every result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            fmpf_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data !== e) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   task automatic send_item(fmpf_pkg::req_type q);
      if (idle_enable && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 12)) @(negedge clock);
      req_data <= q;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(filter_outcome(q));
      @(negedge clock);
      start <= 1'b0;
      // block stays busy here anyway
      @(negedge clock);
   endtask

   task automatic drain;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fmpf_pkg::CSR_FILTER_EN:  filt_en = val;
         fmpf_pkg::CSR_IN_DEFAULT: in_dflt = val;
         default:                  out_dflt = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic fmpf_pkg::req_type rand_item();
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(fmpf_pkg::req_type)-1:0];
   endfunction

   // mostly a well-formed rule with random content; one in ten is random noise
   function automatic fmpf_pkg::req_type rand_rule();
      fmpf_pkg::req_type q;
      q = rand_item();
      q.cmd = fmpf_pkg::CMD_ADD;
      q.protocol = 2'($urandom_range(0, 2));
      q.ip_ver = 2'($urandom_range(0, 2));
      q.rule_action = $urandom_range(0, 1) ? fmpf_pkg::ACT_ALLOW : fmpf_pkg::ACT_DENY;
      q.tag = $urandom_range(0, 7);
      if (q.ip_ver == fmpf_pkg::VER_NONE) q.prefix_length = 8'd0;
      else if (q.ip_ver == fmpf_pkg::VER_V4) q.prefix_length = 8'($urandom_range(0, 32));
      else q.prefix_length = 8'($urandom_range(0, 128));
      if ($urandom_range(0, 2) == 0) begin
         q.port_low = 16'd0;
         q.port_high = 16'd0;
      end else begin
         q.port_low = 16'($urandom_range(1, 40000));
         q.port_high = q.port_low + 16'($urandom_range(0, 20000));
      end
      if ($urandom_range(0, 9) == 0) q = rand_item();  // noise
      return q;
   endfunction

   // packet aimed near an existing rule so matches happen
   function automatic fmpf_pkg::req_type rand_packet();
      fmpf_pkg::req_type  q;
      fmpf_pkg::rule_type r;
      q = rand_item();
      q.cmd = fmpf_pkg::CMD_CHECK;
      q.protocol = 2'($urandom_range(1, 2));
      q.ip_ver = 2'($urandom_range(1, 2));
      q.related_flag = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 3) != 0 && rule_list[q.direction].size() != 0) begin
         r = rule_list[q.direction][$urandom_range(0, rule_list[q.direction].size() - 1)];
         if (r.ver != fmpf_pkg::VER_NONE) q.ip_ver = r.ver;
         q.addr_high = r.addr_hi ^ (64'd1 << $urandom_range(0, 63));
         q.addr_low  = r.addr_lo ^ (64'd1 << $urandom_range(0, 63));
         if (r.pfrom != 16'd0) begin
            q.port_low  = r.pfrom + 16'($urandom_range(0, 1));
            q.port_high = r.pto - 16'($urandom_range(0, 1));
         end
      end
      if ($urandom_range(0, 15) == 0) q = rand_item();
      return q;
   endfunction

   task automatic test_validation;
      fmpf_pkg::req_type q;
      q = '0;
      q.cmd = fmpf_pkg::CMD_ADD; q.rule_action = ACT_NONE; send_item(q);
      q.rule_action = ACT_RSVD; send_item(q);
      q.rule_action = fmpf_pkg::ACT_ALLOW; q.protocol = fmpf_pkg::PROTO_OTHER; send_item(q);
      q.protocol = fmpf_pkg::L4_TCP; q.ip_ver = fmpf_pkg::VER_UNKNOWN; send_item(q);
      q.ip_ver = fmpf_pkg::VER_V4; q.prefix_length = 8'd33; send_item(q);
      q.ip_ver = fmpf_pkg::VER_V6; q.prefix_length = 8'd129; send_item(q);
      q.prefix_length = 8'hFF; send_item(q);
      q.ip_ver = fmpf_pkg::VER_NONE; q.prefix_length = 8'd1; send_item(q);
      q.prefix_length = 8'd0; q.port_low = 16'd5; send_item(q);
      q.port_low = 16'd0; q.port_high = 16'd5; send_item(q);
      q.port_low = 16'd9; q.port_high = 16'd8; send_item(q);
      q.cmd = CMD_RSVD_LO; send_item(q);
      q.cmd = CMD_RSVD_HI; send_item(q);
   endtask

   task automatic test_rules_and_prefix;
      fmpf_pkg::req_type q;
      q = '0;
      q.cmd = fmpf_pkg::CMD_ADD; q.rule_action = fmpf_pkg::ACT_DENY;
      q.protocol = fmpf_pkg::L4_TCP;
      q.ip_ver = fmpf_pkg::VER_V6; q.prefix_length = 8'd128;
      q.addr_high = '1; q.addr_low = '1; q.port_low = 16'd1; q.port_high = 16'hFFFF;
      q.tag = 32'hFFFF_FFFF; send_item(q);
      q.ip_ver = fmpf_pkg::VER_V4; q.prefix_length = 8'd32; send_item(q);
      q.cmd = fmpf_pkg::CMD_CHECK; q.port_low = 16'hFFFF; q.port_high = 16'hFFFF;
      send_item(q);
      q.ip_ver = fmpf_pkg::VER_V6; send_item(q);
      q.addr_low = 64'd1; q.addr_high = 64'd0; send_item(q);         // v6 loopback
      q.ip_ver = fmpf_pkg::VER_V4; q.addr_low = 64'h7F00_0001; send_item(q); // v4 loopback
      q.ip_ver = fmpf_pkg::VER_NONE; send_item(q);
      q.ip_ver = fmpf_pkg::VER_UNKNOWN; send_item(q);
      q.ip_ver = fmpf_pkg::VER_V4; q.protocol = fmpf_pkg::PROTO_OTHER; send_item(q);
      q.protocol = fmpf_pkg::L4_UDP; q.related_flag = 1'b1; q.direction = 1'b1;
      send_item(q);
      q.cmd = fmpf_pkg::CMD_REM_ID; q.tag = 32'd0; send_item(q);
      q.tag = 32'd1; send_item(q);
      q.tag = 32'd1; send_item(q);
      q.cmd = fmpf_pkg::CMD_REM_OWNER; q.tag = 32'd0; send_item(q);
      q.tag = 32'h0000_FFFF; send_item(q);
      q.cmd = fmpf_pkg::CMD_CLEAR; send_item(q);
      drain();
   endtask

   // fill one list past capacity, then remove the rules of owner 3
   task automatic test_full_table;
      fmpf_pkg::req_type q;
      for (int i = 0; i < fmpf_pkg::RULES_PER_DIRECTION + 2; i++) begin
         q = rand_rule();
         q.cmd = fmpf_pkg::CMD_ADD; q.rule_action = fmpf_pkg::ACT_ALLOW;
         q.ip_ver = fmpf_pkg::VER_NONE;
         q.prefix_length = 8'd0; q.port_low = 16'd0; q.port_high = 16'd0;
         q.protocol = fmpf_pkg::PROTO_ANY; q.direction = 1'b1;
         send_item(q);
      end
      q.cmd = fmpf_pkg::CMD_REM_OWNER; q.tag = 32'd3; send_item(q);
      drain();
   endtask

   task automatic test_random(int n, logic en, logic ind, logic outd);
      fmpf_pkg::req_type q;
      write_reg(fmpf_pkg::CSR_FILTER_EN, en);
      write_reg(fmpf_pkg::CSR_IN_DEFAULT, ind);
      write_reg(fmpf_pkg::CSR_OUT_DEFAULT, outd);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: q = rand_rule();
            6: begin
               q = rand_item(); q.cmd = fmpf_pkg::CMD_REM_ID;
               q.tag = (next_id > 32'd1) ? $urandom_range(1, next_id) : 32'd1;
               if ($urandom_range(0, 7) == 0) q.tag = $urandom;
            end
            7: begin
               q = rand_item(); q.cmd = fmpf_pkg::CMD_REM_OWNER;
               q.tag = $urandom_range(0, 7);
            end
            8: begin
               q = rand_item();
               q.cmd = ($urandom_range(0, 3) == 0) ? fmpf_pkg::CMD_CLEAR : CMD_RSVD_LO;
            end
            default: q = rand_packet();
         endcase
         send_item(q);
      end
      // sender holds off until every result has come
      drain();
   endtask

   initial begin
      filt_en = 1'b1; in_dflt = 1'b0; out_dflt = 1'b1; next_id = 32'd1;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_validation();
      test_rules_and_prefix();
      test_full_table();
      test_random(300, 1'b1, 1'b0, 1'b1);
      test_random(300, 1'b1, 1'b1, 1'b0);
      test_random(150, 1'b0, 1'b1, 1'b1);
      idle_enable = 1'b0;
      test_random(400, 1'b1, 1'b0, 1'b0);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: first_match_packet_filter_core.f
rtl/fmpf_pkg.sv
rtl/fmpf_cell.sv
rtl/first_match_packet_filter_core.sv
rtl/fmpf_checker.sv
dv/tb.sv
